// ===== design/clnws_pkg.sv =====
package clnws_pkg;

    localparam int unsigned FuncW   = 2;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned NibW    = 4;
    localparam int unsigned PinW    = 7;
    localparam int unsigned LimitW  = 16;

    localparam logic [LimitW-1:0] LimitReset = 16'd1000;
    localparam logic [LimitW-1:0] PollsMax   = 16'hFFFF;

    localparam logic [FuncW-1:0] FUNC_CMD    = 2'd0;
    localparam logic [FuncW-1:0] FUNC_DATA   = 2'd1;
    localparam logic [FuncW-1:0] FUNC_SAMPLE = 2'd2;

    localparam int unsigned BusyBit = 3;

    // pin_value bit positions
    localparam int unsigned PinRead = 6;
    localparam int unsigned PinRs   = 5;
    localparam int unsigned PinEn   = 4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    // One step per result of a run
    typedef enum logic [8:0] {
        S_ZERO = 9'b000000001,
        S_HI1  = 9'b000000010,
        S_HIEN = 9'b000000100,
        S_HI2  = 9'b000001000,
        S_LO1  = 9'b000010000,
        S_LOEN = 9'b000100000,
        S_LO2  = 9'b001000000,
        S_RD   = 9'b010000000,
        S_RDEN = 9'b100000000
    } t_step;

endpackage

// ===== design/char_lcd_nibble_write_sequencer.sv =====
// Write sequencer for a character LCD on a 4-bit data bus.
// Input channel (i_in_valid / o_in_stall): a command or data write request
// (func 0 or 1, i_byte_value) or a sampled bus nibble (func 2,
// i_bus_nibble). Requests arriving out of turn are taken and dropped.
// Output channel (o_out_valid / i_out_stall): one pin drive per cycle unless stalled.
// A write request yields a busy poll of two drives; the first sample gives
// two more; the second sample gives a zero drive followed by either a new
// poll (busy and retry limit not spent) or the six drives of the byte write.
// o_last marks the end of each run, o_want_sample the drive after which a
// sample is expected.
// The first drive of a run is valid the cycle after the request is
// taken. The run register holds one run; the next request is taken in the
// cycle the final drive of the current run is taken, so the output never
// idles while in-turn requests are waiting.
// A stalled output holds its drive and stalls the input behind it.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes the
// busy retry limit, which resets to 1000.
// Synchronous active-low reset returns to idle with no run pending.
module char_lcd_nibble_write_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [clnws_pkg::FuncW-1:0]    i_func,
    input  logic [clnws_pkg::ByteW-1:0]    i_byte_value,
    input  logic [clnws_pkg::NibW-1:0]     i_bus_nibble,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [clnws_pkg::PinW-1:0]     o_pin_value,
    output logic                           o_drive_data,
    output logic                           o_want_sample,
    output logic                           o_last,
    output logic                           o_write_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [clnws_pkg::LimitW-1:0]   i_cfg_data
);
    import clnws_pkg::*;

    logic [LimitW-1:0] r_limit;
    t_phase            r_phase, n_phase;
    logic [ByteW-1:0]  r_byte, n_byte;
    logic              r_sel, n_sel;
    logic [LimitW-1:0] r_polls, n_polls;
    logic              r_busy, n_busy;
    logic              r_run_valid, n_run_valid;
    t_step             r_step, n_step;
    logic              r_repoll, n_repoll;

    logic              in_take, out_take, run_end, start;
    t_step             start_step, next_step;
    logic              start_repoll;
    logic [LimitW-1:0] polls_inc;
    logic [NibW-1:0]   nib_sel;

    assign out_take   = r_run_valid && !i_out_stall;
    assign run_end    = out_take && (r_step == S_RDEN || r_step == S_LO2);
    assign o_in_stall = r_run_valid && !run_end;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign polls_inc = (r_polls == PollsMax) ? r_polls : r_polls + 1'b1;

    // request decode and phase update
    always_comb begin
        n_phase      = r_phase;
        n_byte       = r_byte;
        n_sel        = r_sel;
        n_polls      = r_polls;
        n_busy       = r_busy;
        start        = 1'b0;
        start_step   = S_RD;
        start_repoll = 1'b0;
        if (in_take) begin
            if ((i_func == FUNC_CMD || i_func == FUNC_DATA) && r_phase == PH_IDLE) begin
                n_byte  = i_byte_value;
                n_sel   = i_func[0];
                n_polls = '0;
                n_busy  = 1'b0;
                n_phase = PH_HIGH;
                start   = 1'b1;
            end else if (i_func == FUNC_SAMPLE && r_phase == PH_HIGH) begin
                n_busy  = i_bus_nibble[BusyBit];
                n_phase = PH_LOW;
                start   = 1'b1;
            end else if (i_func == FUNC_SAMPLE && r_phase == PH_LOW) begin
                n_polls    = polls_inc;
                start      = 1'b1;
                start_step = S_ZERO;
                if (r_busy && polls_inc < r_limit) begin
                    n_phase      = PH_HIGH;
                    start_repoll = 1'b1;
                end else begin
                    n_phase = PH_IDLE;
                    n_busy  = 1'b0;
                end
            end
        end
    end

    always_comb begin
        case (r_step)
            S_ZERO:  next_step = r_repoll ? S_RD : S_HI1;
            S_HI1:   next_step = S_HIEN;
            S_HIEN:  next_step = S_HI2;
            S_HI2:   next_step = S_LO1;
            S_LO1:   next_step = S_LOEN;
            S_LOEN:  next_step = S_LO2;
            S_RD:    next_step = S_RDEN;
            default: next_step = r_step;
        endcase
    end

    always_comb begin
        n_run_valid = r_run_valid;
        n_step      = r_step;
        n_repoll    = r_repoll;
        if (start) begin
            n_run_valid = 1'b1;
            n_step      = start_step;
            n_repoll    = start_repoll;
        end else if (run_end) begin
            n_run_valid = 1'b0;
        end else if (out_take) begin
            n_step = next_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LimitReset;
            r_phase     <= PH_IDLE;
            r_busy      <= 1'b0;
            r_run_valid <= 1'b0;
            r_step      <= S_RD;
            r_repoll    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_busy      <= n_busy;
            r_run_valid <= n_run_valid;
            r_step      <= n_step;
            r_repoll    <= n_repoll;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_sel   <= n_sel;
        r_polls <= n_polls;
    end

    // pin drive for the current step
    assign nib_sel = (r_step == S_HI1 || r_step == S_HIEN || r_step == S_HI2) ?
                     r_byte[ByteW-1:NibW] : r_byte[NibW-1:0];

    always_comb begin
        o_pin_value   = '0;
        o_drive_data  = 1'b0;
        o_want_sample = 1'b0;
        o_last        = 1'b0;
        o_write_done  = 1'b0;
        case (r_step)
            S_ZERO: begin
            end
            S_RD: begin
                o_pin_value[PinRead] = 1'b1;
            end
            S_RDEN: begin
                o_pin_value[PinRead] = 1'b1;
                o_pin_value[PinEn]   = 1'b1;
                o_want_sample        = 1'b1;
                o_last               = 1'b1;
            end
            default: begin
                o_pin_value[NibW-1:0] = nib_sel;
                o_pin_value[PinRs]    = r_sel;
                o_pin_value[PinEn]    = (r_step == S_HIEN || r_step == S_LOEN);
                o_drive_data          = 1'b1;
                o_last                = (r_step == S_LO2);
                o_write_done          = (r_step == S_LO2);
            end
        endcase
    end

    assign o_out_valid = r_run_valid;

`ifndef ASSERT_OFF
    a_hold_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid && i_out_stall |=> r_run_valid && $stable(r_step))
        else $error("run step moved while output stalled");

    a_want_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_want_sample |-> r_phase != PH_IDLE)
        else $error("sample requested while idle");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_data |-> r_phase == PH_IDLE)
        else $error("byte write driven while polling");
`endif

endmodule
